@@ rtl/key_table_linear_and_binary_search_assert.svh @@
// Assertion macros shared by the key table checker.
`ifndef KEY_TABLE_LINEAR_AND_BINARY_SEARCH_ASSERT_SVH
`define KEY_TABLE_LINEAR_AND_BINARY_SEARCH_ASSERT_SVH

// same-cycle implication
`define KTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/kts_pkg.sv @@
// Types and codes shared by the key table search block.
`timescale 1ns / 1ps
`default_nettype none

package kts_pkg;

	localparam int KEY_W   = 37;
	localparam int TAG_W   = 10;
	localparam int PROBE_W = 11;
	localparam int MODE_W  = 3;
	localparam int STAT_W  = 2;

	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FWD   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REV   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_BIN   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FOUND    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
	} in_word_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [TAG_W-1:0]   entry_tag;
		logic [PROBE_W-1:0] probes;
	} out_word_t;

	// one table entry: key and its load position
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

endpackage

`default_nettype wire

@@ rtl/kts_ram.sv @@
// Single-port-write, single-port-read entry RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kts_ram
	import kts_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire entry_t                     wr_data,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output entry_t                          rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/key_table_linear_and_binary_search.sv @@
// Key table with forward scan, reverse scan and sort-then-binary search.
// A word is taken when start is high and busy is low; its result appears on
// result for one cycle with done high and must be captured then, since the
// receiver cannot hold it off. Clear, load and unused modes answer with done
// on the next cycle. A forward or reverse scan over n entries makes one RAM
// read per entry and stops at the first match. A binary search first runs the
// exchange sort for n of two or more, then passes through ST_BS_ADDR and
// ST_BS_CMP for each probe. All timing is set by the single read port of the
// entry RAM. Entries are not cleared after reset; only loaded entries' data is used.
`timescale 1ns / 1ps
`default_nettype none

module key_table_linear_and_binary_search
	import kts_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire in_word_t  cmd,
	output logic           done,
	output out_word_t      result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SORT_LD,
		ST_SORT_CMP,
		ST_SORT_WB,
		ST_BS_ADDR,
		ST_BS_CMP
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    probes_q;
	logic [CW-1:0]    left_q;
	logic [AW-1:0]    nxt_q;
	logic             rev_q;
	logic [AW-1:0]    last_q;
	logic [AW-1:0]    i_q;
	logic [AW-1:0]    j_q;
	entry_t           hold_q;
	logic [AW-1:0]    lo_q;
	logic [AW-1:0]    hi_q;
	logic [AW-1:0]    mid_q;
	out_word_t        result_q;
	logic             done_q;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	entry_t           wr_data;
	logic [AW-1:0]    rd_addr;
	entry_t           rd_data;

	logic [CW-1:0]    probes_inc;
	logic [AW:0]      mid_sum;
	logic [AW-1:0]    mid;
	logic             full;
	logic             swap;

	assign probes_inc = probes_q + CW'(1);
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[AW:1];
	assign full       = (count_q == CW'(DEPTH));
	assign swap       = (hold_q.key > rd_data.key);

	kts_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = hold_q;
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = (cmd.mode == MODE_REV) ? AW'(count_q - CW'(1)) : '0;
				if (start && cmd.mode == MODE_LOAD && !full) begin
					wr_en   = 1'b1;
					wr_addr = AW'(count_q);
					wr_data = '{key: cmd.key, tag: TAG_W'(count_q)};
				end
			end
			ST_SCAN:     rd_addr = nxt_q;
			ST_SORT_LD:  rd_addr = j_q;
			ST_SORT_CMP: begin
				rd_addr = j_q + AW'(1);
				// entry j takes the held entry i, held copy takes entry j
				if (swap) begin
					wr_en   = 1'b1;
					wr_addr = j_q;
				end
			end
			ST_SORT_WB: begin
				rd_addr = i_q + AW'(1);
				wr_en   = 1'b1;
			end
			ST_BS_ADDR:  rd_addr = mid;
			ST_BS_CMP:   rd_addr = mid_q;
			default:     rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
			key_q    <= '0;
			probes_q <= '0;
			left_q   <= '0;
			nxt_q    <= '0;
			rev_q    <= 1'b0;
			last_q   <= '0;
			i_q      <= '0;
			j_q      <= '0;
			hold_q   <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						key_q    <= cmd.key;
						probes_q <= '0;
						last_q   <= AW'(count_q - CW'(1));
						unique case (cmd.mode) inside
							MODE_CLEAR: begin
								count_q  <= '0;
								result_q <= '{STAT_DONE, '0, '0};
								done_q   <= 1'b1;
							end
							MODE_LOAD: begin
								if (full) begin
									result_q <= '{STAT_FULL, '0, '0};
								end else begin
									count_q  <= count_q + CW'(1);
									result_q <= '{STAT_DONE, '0, '0};
								end
								done_q <= 1'b1;
							end
							MODE_FWD, MODE_REV: begin
								if (count_q == '0) begin
									result_q <= '{STAT_NOTFOUND, '0, '0};
									done_q   <= 1'b1;
								end else begin
									rev_q   <= (cmd.mode == MODE_REV);
									nxt_q   <= (cmd.mode == MODE_REV) ?
										AW'(count_q - CW'(2)) : AW'(1);
									left_q  <= count_q;
									state_q <= ST_SCAN;
								end
							end
							MODE_BIN: begin
								if (count_q == '0) begin
									result_q <= '{STAT_NOTFOUND, '0, '0};
									done_q   <= 1'b1;
								end else if (count_q == CW'(1)) begin
									lo_q    <= '0;
									hi_q    <= '0;
									state_q <= ST_BS_ADDR;
								end else begin
									i_q     <= '0;
									j_q     <= AW'(1);
									state_q <= ST_SORT_LD;
								end
							end
							default: begin
								result_q <= '{STAT_DONE, '0, '0};
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					probes_q <= probes_inc;
					if (rd_data.key == key_q) begin
						result_q <= '{STAT_FOUND, rd_data.tag, PROBE_W'(probes_inc)};
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (left_q == CW'(1)) begin
						result_q <= '{STAT_NOTFOUND, '0, PROBE_W'(probes_inc)};
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						nxt_q  <= rev_q ? nxt_q - AW'(1) : nxt_q + AW'(1);
						left_q <= left_q - CW'(1);
					end
				end
				ST_SORT_LD: begin
					hold_q  <= rd_data;
					state_q <= ST_SORT_CMP;
				end
				ST_SORT_CMP: begin
					if (swap) begin
						hold_q <= rd_data;
					end
					j_q <= j_q + AW'(1);
					if (j_q == last_q) begin
						state_q <= ST_SORT_WB;
					end
				end
				ST_SORT_WB: begin
					i_q <= i_q + AW'(1);
					j_q <= i_q + AW'(2);
					if (i_q + AW'(1) == last_q) begin
						lo_q    <= '0;
						hi_q    <= last_q;
						state_q <= ST_BS_ADDR;
					end else begin
						state_q <= ST_SORT_LD;
					end
				end
				ST_BS_ADDR: begin
					mid_q   <= mid;
					state_q <= ST_BS_CMP;
				end
				ST_BS_CMP: begin
					probes_q <= probes_inc;
					if (rd_data.key == key_q) begin
						result_q <= '{STAT_FOUND, rd_data.tag, PROBE_W'(probes_inc)};
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (rd_data.key < key_q) begin
						if (mid_q == hi_q) begin
							result_q <= '{STAT_NOTFOUND, '0, PROBE_W'(probes_inc)};
							done_q   <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							lo_q    <= mid_q + AW'(1);
							state_q <= ST_BS_ADDR;
						end
					end else begin
						if (mid_q == lo_q) begin
							result_q <= '{STAT_NOTFOUND, '0, PROBE_W'(probes_inc)};
							done_q   <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							hi_q    <= mid_q - AW'(1);
							state_q <= ST_BS_ADDR;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ rtl/kts_checker.sv @@
// Port-level checks for the key table search block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "key_table_linear_and_binary_search_assert.svh"

module kts_checker
	import kts_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire in_word_t  cmd,
	input wire logic      done,
	input wire out_word_t result
);

	// a search that finishes leaves busy together with its result
	`KTS_ASSERT_IMP(a_fell_busy_done, clk, arst_n, $fell(busy), done, "busy fell without result")

	// no result appears without a word taken or in flight
	`KTS_ASSERT_IMP(a_done_has_word, clk, arst_n, done, $past(busy) || $past(start), "result without word")

	// tag only reported on a hit
	`KTS_ASSERT_IMP(a_tag_on_hit, clk, arst_n, done && result.status != STAT_FOUND, result.entry_tag == '0, "tag set without hit")

	// clear, load and unused modes answer on the next cycle with no probes
	`KTS_ASSERT_NXT(a_quick_modes, clk, arst_n, start && !busy && (cmd.mode == MODE_CLEAR || cmd.mode == MODE_LOAD || cmd.mode > MODE_BIN), done && result.probes == '0, "quick mode late or probed")

endmodule

bind key_table_linear_and_binary_search kts_checker u_kts_checker (.*);

`default_nettype wire

@@ tb/tb_key_table_linear_and_binary_search.sv @@
// Self-checking testbench for the key table with scan and binary search.
`timescale 1ns / 1ps

module tb_key_table_linear_and_binary_search;
	import kts_pkg::*;

	localparam int DEPTH = 1024;
	localparam int RANDOM_WORDS = 580;
	// slowest legal silence: one full-table sort, taken several times over
	localparam int STALL_LIMIT = 4 * (DEPTH * DEPTH / 2 + 4 * DEPTH);
	localparam logic [KEY_W-1:0] KEY_MAX = 37'd99999999999;
	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_word_t  cmd = '0;
	logic      done;
	out_word_t result;

	key_table_linear_and_binary_search #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// shadow copy of the table
	entry_t    tbl_entry [DEPTH];
	int        tbl_count = 0;
	out_word_t lookup_results_q [$];

	int  mismatches = 0;
	int  results_checked = 0;
	int  words_sent = 0;
	int  found_count = 0;
	int  miss_count = 0;
	int  full_count = 0;
	int  stall_cycles = 0;
	bit  gaps_on = 1'b1;

	function automatic void exchange_sort_table();
		entry_t tmp;
		for (int i = 0; i < tbl_count; i++) begin
			for (int j = i + 1; j < tbl_count; j++) begin
				if (tbl_entry[i].key > tbl_entry[j].key) begin
					tmp = tbl_entry[i];
					tbl_entry[i] = tbl_entry[j];
					tbl_entry[j] = tmp;
				end
			end
		end
	endfunction

	function automatic out_word_t table_lookup(in_word_t w);
		out_word_t r;
		int        probe_n;
		int        lo;
		int        hi;
		int        mid;
		bit        hit;
		r = '0;
		r.status = STAT_DONE;
		probe_n = 0;
		hit = 1'b0;
		case (w.mode)
			MODE_CLEAR: tbl_count = 0;
			MODE_LOAD: begin
				if (tbl_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					tbl_entry[tbl_count].key = w.key;
					tbl_entry[tbl_count].tag = TAG_W'(tbl_count);
					tbl_count++;
				end
			end
			MODE_FWD: begin
				for (int i = 0; i < tbl_count && !hit; i++) begin
					probe_n++;
					if (tbl_entry[i].key == w.key) begin
						hit = 1'b1;
						r.entry_tag = tbl_entry[i].tag;
					end
				end
			end
			MODE_REV: begin
				for (int i = tbl_count - 1; i >= 0 && !hit; i--) begin
					probe_n++;
					if (tbl_entry[i].key == w.key) begin
						hit = 1'b1;
						r.entry_tag = tbl_entry[i].tag;
					end
				end
			end
			MODE_BIN: begin
				exchange_sort_table();
				lo = 0;
				hi = tbl_count - 1;
				while (hi >= lo && !hit) begin
					mid = (lo + hi) / 2;
					probe_n++;
					if (tbl_entry[mid].key == w.key) begin
						hit = 1'b1;
						r.entry_tag = tbl_entry[mid].tag;
					end else if (tbl_entry[mid].key < w.key) begin
						lo = mid + 1;
					end else begin
						hi = mid - 1;
					end
				end
			end
			default: r.status = STAT_DONE;
		endcase
		if (w.mode == MODE_FWD || w.mode == MODE_REV || w.mode == MODE_BIN)
			r.status = hit ? STAT_FOUND : STAT_NOTFOUND;
		r.probes = PROBE_W'(probe_n);
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		logic [63:0] raw;
		case ($urandom_range(15))
			0: return '0;
			1: return KEY_MAX;
			default: begin
				raw = {$urandom, $urandom};
				return KEY_W'(raw % (64'(KEY_MAX) + 64'd1));
			end
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] rand_search_mode();
		case ($urandom_range(2))
			0: return MODE_FWD;
			1: return MODE_REV;
			default: return MODE_BIN;
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] rand_spare_mode();
		case ($urandom_range(2))
			0: return MODE_SPARE_A;
			1: return MODE_SPARE_B;
			default: return MODE_SPARE_C;
		endcase
	endfunction

	// leaves start high unless a gap is taken; caller sends again or calls wait_idle
	task automatic send_word(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key);
		in_word_t  w;
		out_word_t r;
		w.mode = mode;
		w.key = key;
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy !== 1'b0);
		r = table_lookup(w);
		lookup_results_q.push_back(r);
		if (mode <= MODE_BIN)
			words_sent++;
		case (r.status)
			STAT_FOUND:    found_count++;
			STAT_NOTFOUND: miss_count++;
			STAT_FULL:     full_count++;
			default: ;
		endcase
		if (gaps_on && $urandom_range(99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (lookup_results_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_empty_table();
		send_word(MODE_FWD, '0);
		send_word(MODE_REV, KEY_MAX);
		send_word(MODE_BIN, 37'd1);
		send_word(MODE_SPARE_A, KEY_MAX);
		send_word(MODE_SPARE_B, '0);
		send_word(MODE_SPARE_C, KEY_MAX);
		send_word(MODE_CLEAR, KEY_MAX);
		wait_idle();
	endtask

	task automatic test_small_table();
		send_word(MODE_CLEAR, '0);
		send_word(MODE_LOAD, '0);
		send_word(MODE_LOAD, KEY_MAX);
		send_word(MODE_LOAD, 37'd5);
		send_word(MODE_LOAD, 37'd5);
		send_word(MODE_LOAD, 37'd42);
		send_word(MODE_LOAD, 37'd7);
		// duplicate: forward finds the first, reverse the last
		send_word(MODE_FWD, 37'd5);
		send_word(MODE_REV, 37'd5);
		send_word(MODE_FWD, KEY_MAX);
		send_word(MODE_REV, '0);
		send_word(MODE_FWD, 37'd1234);
		send_word(MODE_REV, 37'd1234);
		send_word(MODE_BIN, 37'd42);
		send_word(MODE_BIN, '0);
		send_word(MODE_BIN, KEY_MAX);
		send_word(MODE_BIN, 37'd6);
		// appended after the sort; binary search finds it only by re-sorting
		send_word(MODE_LOAD, 37'd3);
		send_word(MODE_FWD, 37'd3);
		send_word(MODE_BIN, 37'd3);
		send_word(MODE_BIN, 37'd5);
		wait_idle();
	endtask

	task automatic test_full_table();
		int               idx;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] dup_key;
		send_word(MODE_CLEAR, '0);
		dup_key = '0;
		for (idx = 0; idx < DEPTH; idx++) begin
			if (idx == DEPTH - 1)
				k = '0;
			else if (idx == DEPTH / 2)
				k = dup_key;
			else
				k = KEY_MAX - KEY_W'(idx * 97);
			if (idx < DEPTH / 2)
				dup_key = k;
			send_word(MODE_LOAD, k);
		end
		send_word(MODE_LOAD, 37'd77);
		send_word(MODE_FWD, '0);
		send_word(MODE_REV, KEY_MAX);
		send_word(MODE_FWD, 37'd1);
		send_word(MODE_REV, 37'd1);
		send_word(MODE_LOAD, KEY_MAX);
		// one full-size sort only: it dominates the run time
		send_word(MODE_BIN, dup_key);
		send_word(MODE_FWD, dup_key);
		send_word(MODE_CLEAR, KEY_MAX);
		wait_idle();
	endtask

	task automatic test_random_sequences();
		logic [KEY_W-1:0] loaded [$];
		logic [KEY_W-1:0] k;
		int               first_word;
		int               n;
		int               sent;
		first_word = words_sent;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			// a long stretch back to back in the middle
			gaps_on = !(sent > RANDOM_WORDS / 3 && sent < 2 * RANDOM_WORDS / 3);
			if (tbl_count > 40 || $urandom_range(3) != 0) begin
				send_word(MODE_CLEAR, rand_key());
				loaded.delete();
			end
			n = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 12);
			repeat (n) begin
				k = ($urandom_range(2) == 0) ? KEY_W'($urandom_range(15)) : rand_key();
				send_word(MODE_LOAD, k);
				loaded.push_back(k);
			end
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(19))
					0: send_word(rand_spare_mode(), rand_key());
					1: begin
						k = rand_key();
						send_word(MODE_LOAD, k);
						loaded.push_back(k);
					end
					default: begin
						if (loaded.size() != 0 && $urandom_range(2) != 0)
							k = loaded[$urandom_range(loaded.size() - 1)];
						else
							k = rand_key();
						send_word(rand_search_mode(), k);
					end
				endcase
			end
			if ($urandom_range(9) == 0)
				wait_idle();
			sent = words_sent - first_word;
		end
		gaps_on = 1'b1;
		wait_idle();
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && done === 1'b1) begin
			results_checked++;
			if (lookup_results_q.size() == 0) begin
				$error("result word with nothing pending: status %0d tag %0d probes %0d",
					result.status, result.entry_tag, result.probes);
				mismatches++;
			end else begin
				want = lookup_results_q.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatches++;
				end
				if (result.entry_tag !== want.entry_tag) begin
					$error("entry_tag: expected %0d, got %0d", want.entry_tag, result.entry_tag);
					mismatches++;
				end
				if (result.probes !== want.probes) begin
					$error("probes: expected %0d, got %0d", want.probes, result.probes);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
				$display("key_table_linear_and_binary_search regression: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_small_table();
		test_full_table();
		test_random_sequences();
		wait_idle();
		repeat (2 * DEPTH + 32) @(posedge clk);
		$display("covered %0d table commands: %0d hits, %0d misses, %0d dropped loads",
			words_sent, found_count, miss_count, full_count);
		$display("%0d result words checked, %0d field mismatches", results_checked, mismatches);
		if (mismatches == 0 && lookup_results_q.size() == 0)
			$display("key_table_linear_and_binary_search regression: pass");
		else
			$display("key_table_linear_and_binary_search regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/kts_pkg.sv
rtl/kts_ram.sv
rtl/key_table_linear_and_binary_search.sv
rtl/kts_checker.sv
tb/tb_key_table_linear_and_binary_search.sv
